// ===== design/sna_pkg.sv =====
// ----------------------------------------------------------------------------
// SEI NAL builder package
// Shared types, constants and byte tables for the SEI NAL unit builder.
// ----------------------------------------------------------------------------
package sna_pkg;

	localparam int unsigned HdrBytes   = 5;
	localparam int unsigned RbspBytes  = 35;
	localparam int unsigned DataBytes  = 16;
	localparam int unsigned UnitBytes  = HdrBytes + RbspBytes;
	localparam int unsigned IdxW       = $clog2(UnitBytes);
	localparam int unsigned DataW      = 8 * DataBytes;
	localparam int unsigned DataFirst  = 18;
	localparam int unsigned TrailPos   = 34;

	localparam logic [7:0] EscByte     = 8'h03;
	localparam logic [7:0] TrailByte   = 8'h80;
	localparam logic [7:0] NalTypeSei  = 8'h06;
	localparam logic [7:0] PayloadType = 8'd5;
	localparam logic [7:0] PayloadSize = 8'd32;

	typedef struct packed {
		logic [DataW-1:0]     data;
		logic [DataBytes-1:0] zero_mask;
		logic [DataBytes-1:0] small_mask;
	} stamp_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	function automatic logic [7:0] header_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd3:    b = 8'h01;
			3'd4:    b = NalTypeSei;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] uuid_byte(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = 8'h2D;
			4'd1:    b = 8'h4F;
			4'd2:    b = 8'h31;
			4'd3:    b = 8'h8A;
			4'd4:    b = 8'hB6;
			4'd5:    b = 8'h34;
			4'd6:    b = 8'h4F;
			4'd7:    b = 8'h72;
			4'd8:    b = 8'h9A;
			4'd9:    b = 8'h42;
			4'd10:   b = 8'h52;
			4'd11:   b = 8'h53;
			4'd12:   b = 8'h54;
			4'd13:   b = 8'h53;
			4'd14:   b = 8'h00;
			default: b = 8'h01;
		endcase
		return b;
	endfunction

endpackage

// ===== design/sna_front.sv =====
// ----------------------------------------------------------------------------
// SEI NAL builder front stage
// Accepts stamp requests, packs the fields big-endian and marks the data
// bytes that are zero or small enough to need escaping after a zero run.
// ----------------------------------------------------------------------------
module sna_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [63:0]        camera_time_us,
	input  logic [31:0]        frame_sequence,
	input  logic [31:0]        time_domain,
	input  sna_pkg::q_status_t q_status,
	output logic               push,
	output sna_pkg::stamp_t    push_data
);
	import sna_pkg::*;

	logic             valid_s1;
	stamp_t           stamp_s1;
	logic [DataW-1:0] packed_data;
	stamp_t           stamp_next;
	logic             accept;

	assign packed_data = {camera_time_us, frame_sequence, time_domain};

	always_comb begin
		stamp_next.data = packed_data;
		for (int k = 0; k < DataBytes; k++) begin
			stamp_next.zero_mask[k]  = (packed_data[DataW-1-8*k -: 8] == 8'h00);
			stamp_next.small_mask[k] = (packed_data[DataW-1-8*k -: 6] == 6'd0);
		end
	end

	assign in_stall  = valid_s1 && q_status.full;
	assign accept    = in_valid && !in_stall;
	assign push      = valid_s1 && !q_status.full;
	assign push_data = stamp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stamp_s1 <= stamp_next;
		end
	end

endmodule

// ===== design/sna_queue.sv =====
// ----------------------------------------------------------------------------
// SEI NAL builder request queue
// Two-entry queue that decouples the front stage from the byte serializer.
// ----------------------------------------------------------------------------
module sna_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sna_pkg::stamp_t    push_data,
	input  logic               pop,
	output sna_pkg::stamp_t    head,
	output sna_pkg::q_status_t status
);
	import sna_pkg::*;

	stamp_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign status.empty = (count_q == 2'd0);
	assign status.full  = (count_q == 2'd2);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== design/sna_back.sv =====
// ----------------------------------------------------------------------------
// SEI NAL builder byte serializer
// Walks each unit one byte a cycle unless stalled, inserts emulation
// prevention bytes and holds each byte in an output register until taken.
// ----------------------------------------------------------------------------
module sna_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sna_pkg::stamp_t    head,
	input  sna_pkg::q_status_t q_status,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         nal_byte,
	output logic               last_byte
);
	import sna_pkg::*;

	logic [IdxW-1:0] idx_q;
	logic [1:0]      zeros_q;
	logic            out_valid_q;
	logic [7:0]      nal_byte_q;
	logic            last_q;

	logic [IdxW-1:0] rpos;
	logic [IdxW-1:0] dpos;
	logic [3:0]      dsel;
	logic [7:0]      cur_byte;
	logic            cur_zero;
	logic            cur_small;
	logic            is_hdr;
	logic            esc;
	logic            load;
	logic            end_byte;

	assign is_hdr = (idx_q < IdxW'(HdrBytes));
	assign rpos   = idx_q - IdxW'(HdrBytes);
	assign dpos   = rpos - IdxW'(DataFirst);
	assign dsel   = dpos[3:0];

	always_comb begin
		cur_byte  = header_byte(idx_q[2:0]);
		cur_zero  = (cur_byte == 8'h00);
		cur_small = (cur_byte[7:2] == 6'd0);
		if (!is_hdr) begin
			if (rpos == 0) begin
				cur_byte = PayloadType;
			end else if (rpos == 1) begin
				cur_byte = PayloadSize;
			end else if (rpos < IdxW'(DataFirst)) begin
				cur_byte = uuid_byte(4'(rpos - IdxW'(2)));
			end else if (rpos < IdxW'(TrailPos)) begin
				cur_byte = head.data[DataW-1-8*dsel -: 8];
			end else begin
				cur_byte = TrailByte;
			end
			if (rpos >= IdxW'(DataFirst) && rpos < IdxW'(TrailPos)) begin
				cur_zero  = head.zero_mask[dsel];
				cur_small = head.small_mask[dsel];
			end else begin
				cur_zero  = (cur_byte == 8'h00);
				cur_small = (cur_byte[7:2] == 6'd0);
			end
		end
	end

	assign esc      = !is_hdr && (zeros_q == 2'd2) && cur_small;
	assign load     = !q_status.empty && (!out_valid_q || !out_stall);
	assign end_byte = (idx_q == IdxW'(UnitBytes - 1)) && !esc;
	assign pop      = load && end_byte;

	assign out_valid = out_valid_q;
	assign nal_byte  = nal_byte_q;
	assign last_byte = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			zeros_q     <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				if (esc) begin
					zeros_q <= 2'd0;
				end else if (end_byte) begin
					idx_q   <= '0;
					zeros_q <= 2'd0;
				end else begin
					idx_q <= idx_q + IdxW'(1);
					if (is_hdr || !cur_zero) begin
						zeros_q <= 2'd0;
					end else if (zeros_q != 2'd2) begin
						zeros_q <= zeros_q + 2'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			nal_byte_q <= esc ? EscByte : cur_byte;
			last_q     <= end_byte;
		end
	end

endmodule

// ===== design/sei_nal_builder.sv =====
// ----------------------------------------------------------------------------
// SEI NAL builder top level
// Turns each stamp request into an H.264 SEI user data NAL unit, one byte per
// cycle while out_stall is low, with emulation prevention on the escaped part.
//
//   channel  direction  handshake             payload
//   in       request    in_valid / in_stall   camera_time_us, frame_sequence,
//                                             time_domain
//   out      byte       out_valid / out_stall nal_byte, last_byte
//
// A unit is 40 to 47 bytes long, written by the byte serializer one byte per
// cycle while out_stall is low.
// The request being sent stays at the head of the two-entry queue, one more
// request can wait behind it and a third in the front stage, so requests are
// stalled only when all three places are taken.
// Reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sei_nal_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] camera_time_us,
	input  logic [31:0] frame_sequence,
	input  logic [31:0] time_domain,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  nal_byte,
	output logic        last_byte
);
	import sna_pkg::*;

	q_status_t q_status;
	stamp_t    push_data;
	stamp_t    head;
	logic      push;
	logic      pop;

	sna_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.camera_time_us (camera_time_us),
		.frame_sequence (frame_sequence),
		.time_domain    (time_domain),
		.q_status       (q_status),
		.push           (push),
		.push_data      (push_data)
	);

	sna_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	sna_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.nal_byte  (nal_byte),
		.last_byte (last_byte)
	);

endmodule

// ===== design/sna_checker.sv =====
// ----------------------------------------------------------------------------
// SEI NAL builder port checker
// Watches the top-level ports for output ordering and handshake rules.
// ----------------------------------------------------------------------------
module sna_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] nal_byte,
	input logic       last_byte
);

	// A stalled byte stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(nal_byte) && $stable(last_byte))
		else $error("stalled output byte changed");

	// Every unit ends with the trailing byte.
	a_last_trail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_byte |-> nal_byte == 8'h80)
		else $error("last byte of a unit is not the trailing byte");

	// A byte taken right after the end of a unit opens the next start code.
	a_next_start: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_byte) ##1 (out_valid && !out_stall)
		|-> nal_byte == 8'h00 && !last_byte)
		else $error("unit does not begin with a start code");

endmodule

bind sei_nal_builder sna_checker u_sna_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.nal_byte  (nal_byte),
	.last_byte (last_byte)
);
